>>> rtl/skt_pkg.sv
`default_nettype none

package skt_pkg;

    localparam int unsigned LETTERS  = 26;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned STATUS_W = 3;

    localparam logic [BYTE_W-1:0] CHAR_LO_A = 8'h61;  // 'a'
    localparam logic [BYTE_W-1:0] CHAR_LO_Z = 8'h7A;  // 'z'
    localparam logic [BYTE_W-1:0] CHAR_UP_A = 8'h41;  // 'A'
    localparam logic [BYTE_W-1:0] CHAR_UP_Z = 8'h5A;  // 'Z'
    localparam logic [BYTE_W-1:0] CHAR_DOT  = 8'h2E;  // '.'
    localparam logic [BYTE_W-1:0] CHAR_SPC  = 8'h20;  // ' '

    typedef enum logic [OPCODE_W-1:0] {
        OP_ASSIGN    = 2'd0,
        OP_TRANSLATE = 2'd1,
        OP_CLEAR_ALL = 2'd2,
        OP_UNUSED    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_TRANSLATED    = 3'd0,
        ST_MAPPED        = 3'd1,
        ST_ENTRY_CLEARED = 3'd2,
        ST_TABLE_CLEARED = 3'd3,
        ST_NOT_LETTER    = 3'd4,
        ST_LETTER_USED   = 3'd5
    } status_t;

    // work classes handed from the front to the back
    typedef enum logic [2:0] {
        K_MAP,
        K_CLEAR_ENTRY,
        K_TRANSLATE,
        K_BLANK,
        K_CLEAR_TABLE,
        K_REJECT
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] cipher_idx;
        logic [IDX_W-1:0] plain_idx;
    } work_t;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    function automatic logic is_lower(input logic [BYTE_W-1:0] b);
        return (b >= CHAR_LO_A) && (b <= CHAR_LO_Z);
    endfunction

    function automatic logic is_upper(input logic [BYTE_W-1:0] b);
        return (b >= CHAR_UP_A) && (b <= CHAR_UP_Z);
    endfunction

    // letter index with case folding; only meaningful for letters
    function automatic logic [IDX_W-1:0] letter_idx(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = is_upper(b) ? (b - CHAR_UP_A) : (b - CHAR_LO_A);
        return d[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/substitution_key_table_unit.sv
`default_nettype none

// Key table for a monoalphabetic substitution solver: 26 entries mapping each
// cipher letter to a guessed plain letter. Every input transfer yields exactly
// one result transfer, in order. Input tuser is the opcode (assign/clear pair,
// translate, clear table); results carry the translated byte in tdata and the
// status code in tuser. Throughput is one transfer per clock while results are
// accepted; a result passes through the two-entry work queue and then the
// table stage register. While a result waits the table stage stalls and the
// work queue still takes up to two more transfers before input backs up.
// Reset leaves every entry unassigned at once.
module substitution_key_table_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] first_byte, [15:8] second_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] result_char
    output logic [2:0]       m_axis_tuser    // [2:0] status
);
    import skt_pkg::*;

    work_t   front_work;
    work_t   q_work;
    logic    q_valid;
    logic    q_ready;
    status_t status;

    skt_front u_front
    (
        .opcode      (opcode_t'(s_axis_tuser)),
        .first_byte  (s_axis_tdata[7:0]),
        .second_byte (s_axis_tdata[15:8]),
        .work        (front_work)
    );

    skt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_work   (front_work),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_work  (q_work)
    );

    skt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_work    (q_work),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (m_axis_tdata),
        .out_status (status)
    );

    assign m_axis_tuser = status;

endmodule

`default_nettype wire

>>> rtl/skt_front.sv
`default_nettype none

module skt_front
(
    input  wire skt_pkg::opcode_t           opcode,
    input  wire logic [skt_pkg::BYTE_W-1:0] first_byte,
    input  wire logic [skt_pkg::BYTE_W-1:0] second_byte,
    output skt_pkg::work_t                  work
);
    import skt_pkg::*;

    logic first_letter;
    logic second_letter;
    logic [IDX_W-1:0] ci;
    logic [IDX_W-1:0] pi;

    assign first_letter  = is_lower(first_byte) || is_upper(first_byte);
    assign second_letter = is_lower(second_byte) || is_upper(second_byte);
    assign ci = letter_idx(first_byte);
    assign pi = letter_idx(second_byte);

    always_comb
    begin
        work.cipher_idx = ci;
        work.plain_idx  = pi;
        unique case (opcode)
            OP_ASSIGN:
            begin
                if (!first_letter || !second_letter)
                    work.kind = K_REJECT;
                else if (ci == pi)
                    work.kind = K_CLEAR_ENTRY;
                else
                    work.kind = K_MAP;
            end
            // translate does not fold case
            OP_TRANSLATE: work.kind = is_lower(first_byte) ? K_TRANSLATE : K_BLANK;
            OP_CLEAR_ALL: work.kind = K_CLEAR_TABLE;
            default:      work.kind = K_REJECT;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/skt_queue.sv
`default_nettype none

module skt_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire skt_pkg::work_t in_work,
    output logic                out_valid,
    input  wire logic           out_ready,
    output skt_pkg::work_t      out_work
);
    import skt_pkg::*;

    work_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (cnt_reg != QCNT_W'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_work  = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/skt_back.sv
`default_nettype none

module skt_back
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire skt_pkg::work_t             in_work,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [skt_pkg::BYTE_W-1:0]      out_char,
    output skt_pkg::status_t                out_status
);
    import skt_pkg::*;

    logic [LETTERS-1:0] key_vld_reg;
    logic [IDX_W-1:0]   key_idx_reg [LETTERS];
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_char_reg;
    status_t            out_status_reg;

    logic               take;
    logic               used;
    logic [BYTE_W-1:0]  char_next;
    status_t            status_next;

    assign in_ready   = !out_valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign out_status = out_status_reg;

    // target letter already held by some entry (the same entry included)
    always_comb
    begin
        used = 1'b0;
        for (int k = 0; k < LETTERS; k++)
            if (key_vld_reg[k] && (key_idx_reg[k] == in_work.plain_idx))
                used = 1'b1;
    end

    always_comb
    begin
        char_next   = '0;
        status_next = ST_NOT_LETTER;
        case (in_work.kind)
            K_MAP:         status_next = used ? ST_LETTER_USED : ST_MAPPED;
            K_CLEAR_ENTRY: status_next = ST_ENTRY_CLEARED;
            K_TRANSLATE:
            begin
                status_next = ST_TRANSLATED;
                char_next   = key_vld_reg[in_work.cipher_idx]
                            ? CHAR_LO_A + BYTE_W'(key_idx_reg[in_work.cipher_idx])
                            : CHAR_DOT;
            end
            K_BLANK:
            begin
                status_next = ST_TRANSLATED;
                char_next   = CHAR_SPC;
            end
            K_CLEAR_TABLE: status_next = ST_TABLE_CLEARED;
            default:       status_next = ST_NOT_LETTER;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take && (in_work.kind == K_MAP) && !used)
            key_idx_reg[in_work.cipher_idx] <= in_work.plain_idx;
        if (take)
        begin
            out_char_reg   <= char_next;
            out_status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                case (in_work.kind)
                    K_MAP:         if (!used) key_vld_reg[in_work.cipher_idx] <= 1'b1;
                    K_CLEAR_ENTRY: key_vld_reg[in_work.cipher_idx] <= 1'b0;
                    K_CLEAR_TABLE: key_vld_reg <= '0;
                    default:       ;
                endcase
            end
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import skt_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int CALM_ITEMS   = 120;   // tail of the run with no idling
    localparam int HOLD_AFTER   = 300;   // transfers taken before the long stall
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        opcode_t    op;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       has_answer;
        logic [7:0] answer_char;
        status_t    answer_status;
    } stim_row_t;

    typedef struct {
        logic [7:0] result_char;
        status_t    status;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [7:0] first_byte, [15:8] second_byte
    logic [1:0]  s_axis_tuser;    // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // [7:0] result_char
    logic [2:0]  m_axis_tuser;    // [2:0] status

    // typed answer travelling alongside the current input transfer
    logic        row_has_answer;
    logic [7:0]  row_answer_char;
    status_t     row_answer_status;

    logic        guess_valid [LETTERS];
    logic [4:0]  guess_letter [LETTERS];
    result_t     pending_results[$];
    stim_row_t   directed[$];

    int          mismatches;
    int          taken_items;
    int          cycle_count;
    bit          calm;
    bit          holding;

    substitution_key_table_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // letter index with case folding
    function automatic logic fold_letter(input logic [7:0] b, output logic [4:0] idx);
        logic [7:0] d;
        idx = '0;
        if (b >= 8'h61 && b <= 8'h7A)
        begin
            d = b - 8'h61;
            idx = d[4:0];
            return 1'b1;
        end
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            d = b - 8'h41;
            idx = d[4:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void wipe_guesses();
        for (int k = 0; k < LETTERS; k++)
        begin
            guess_valid[k] = 1'b0;
            guess_letter[k] = '0;
        end
    endfunction

    // updates the guess table and returns what the block should answer
    function automatic void solve_item(input opcode_t op, input logic [7:0] b1,
                                       input logic [7:0] b2, output logic [7:0] ch,
                                       output status_t st);
        logic [4:0] ci;
        logic [4:0] pi;
        logic       used;
        ch = 8'h00;
        st = ST_NOT_LETTER;
        case (op)
            OP_ASSIGN:
            begin
                if (!fold_letter(b1, ci) || !fold_letter(b2, pi))
                    st = ST_NOT_LETTER;
                else if (ci == pi)
                begin
                    guess_valid[ci] = 1'b0;
                    guess_letter[ci] = '0;
                    st = ST_ENTRY_CLEARED;
                end
                else
                begin
                    used = 1'b0;
                    for (int k = 0; k < LETTERS; k++)
                        if (guess_valid[k] && guess_letter[k] == pi)
                            used = 1'b1;
                    if (used)
                        st = ST_LETTER_USED;
                    else
                    begin
                        guess_valid[ci] = 1'b1;
                        guess_letter[ci] = pi;
                        st = ST_MAPPED;
                    end
                end
            end
            OP_TRANSLATE:
            begin
                // translate never folds case
                if (b1 >= 8'h61 && b1 <= 8'h7A && fold_letter(b1, ci))
                    ch = guess_valid[ci] ? 8'h61 + 8'(guess_letter[ci]) : 8'h2E;
                else
                    ch = 8'h20;
                st = ST_TRANSLATED;
            end
            OP_CLEAR_ALL:
            begin
                wipe_guesses();
                st = ST_TABLE_CLEARED;
            end
            default:
                st = ST_NOT_LETTER;
        endcase
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return base + 8'($urandom_range(0, LETTERS - 1));
    endfunction

    task automatic send_item(input opcode_t op, input logic [7:0] b1, input logic [7:0] b2,
                             input logic has_answer, input logic [7:0] answer_char,
                             input status_t answer_status);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b2, b1};
        s_axis_tuser <= op;
        row_has_answer <= has_answer;
        row_answer_char <= answer_char;
        row_answer_status <= answer_status;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        if (!calm && !holding && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result check first, then prediction of the transfer taken at this edge
    always @(posedge clk)
    begin : scoreboard
        logic [7:0] pch;
        status_t    pst;
        result_t    want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: result_char %0h status %0d",
                           m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata !== want.result_char)
                    begin
                        $error("result_char: expected %0h, got %0h",
                               want.result_char, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                solve_item(opcode_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[15:8],
                           pch, pst);
                if (row_has_answer)
                begin
                    pch = row_answer_char;
                    pst = row_answer_status;
                end
                pending_results.push_back('{pch, pst});
                taken_items++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off to back up the block
    initial
    begin : sink
        int  n;
        bit  hold_done;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && taken_items >= HOLD_AFTER)
            begin
                holding = 1'b1;
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                n = HOLD_CYCLES;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                holding = 1'b0;
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 16);
            end
            else
            begin
                holding = 1'b0;
                m_axis_tready <= 1'b1;
                n = $urandom_range(1, 24);
            end
            repeat (n - 1) @(posedge clk);
        end
    end

    initial
    begin : source
        int         r;
        int         drain;
        opcode_t    op;
        logic [7:0] b1;
        logic [7:0] b2;
        stim_row_t  row;

        mismatches = 0;
        taken_items = 0;
        cycle_count = 0;
        calm = 1'b0;
        holding = 1'b0;
        wipe_guesses();
        rst_n = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        row_has_answer <= 1'b0;
        row_answer_char <= '0;
        row_answer_status <= ST_TRANSLATED;

        // empty table, case rules, rejects, map/clear/used paths, clear all
        directed.push_back('{OP_TRANSLATE, CHAR_LO_A, 8'hFF, 1'b1, CHAR_DOT, ST_TRANSLATED});
        directed.push_back('{OP_TRANSLATE, CHAR_LO_Z, 8'h00, 1'b1, CHAR_DOT, ST_TRANSLATED});
        directed.push_back('{OP_TRANSLATE, CHAR_UP_A, 8'h00, 1'b1, CHAR_SPC, ST_TRANSLATED});
        directed.push_back('{OP_TRANSLATE, 8'h00, 8'h00, 1'b1, CHAR_SPC, ST_TRANSLATED});
        directed.push_back('{OP_TRANSLATE, 8'hFF, 8'hFF, 1'b1, CHAR_SPC, ST_TRANSLATED});
        directed.push_back('{OP_ASSIGN, 8'h00, CHAR_LO_A, 1'b1, 8'h00, ST_NOT_LETTER});
        directed.push_back('{OP_ASSIGN, CHAR_LO_A, 8'hFF, 1'b1, 8'h00, ST_NOT_LETTER});
        directed.push_back('{OP_ASSIGN, 8'h40, "b", 1'b1, 8'h00, ST_NOT_LETTER});
        directed.push_back('{OP_ASSIGN, 8'h5B, 8'h60, 1'b1, 8'h00, ST_NOT_LETTER});
        directed.push_back('{OP_ASSIGN, CHAR_LO_Z, 8'h7B, 1'b1, 8'h00, ST_NOT_LETTER});
        directed.push_back('{OP_ASSIGN, "a", "b", 1'b0, 8'h00, ST_MAPPED});
        directed.push_back('{OP_ASSIGN, "c", "B", 1'b0, 8'h00, ST_MAPPED});
        directed.push_back('{OP_ASSIGN, "a", "b", 1'b0, 8'h00, ST_MAPPED});
        directed.push_back('{OP_TRANSLATE, "a", 8'h00, 1'b0, 8'h00, ST_TRANSLATED});
        directed.push_back('{OP_ASSIGN, "Z", "A", 1'b0, 8'h00, ST_MAPPED});
        directed.push_back('{OP_TRANSLATE, "z", 8'h00, 1'b0, 8'h00, ST_TRANSLATED});
        directed.push_back('{OP_ASSIGN, "A", "a", 1'b0, 8'h00, ST_MAPPED});
        directed.push_back('{OP_TRANSLATE, "a", 8'h00, 1'b0, 8'h00, ST_TRANSLATED});
        directed.push_back('{OP_ASSIGN, "m", "M", 1'b0, 8'h00, ST_MAPPED});
        directed.push_back('{OP_UNUSED, 8'hFF, 8'hFF, 1'b1, 8'h00, ST_NOT_LETTER});
        directed.push_back('{OP_CLEAR_ALL, 8'h00, 8'h00, 1'b1, 8'h00, ST_TABLE_CLEARED});
        directed.push_back('{OP_TRANSLATE, "z", 8'h00, 1'b1, CHAR_DOT, ST_TRANSLATED});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            row = directed[i];
            send_item(row.op, row.first_byte, row.second_byte, row.has_answer,
                      row.answer_char, row.answer_status);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            r = $urandom_range(0, 99);
            b1 = 8'($urandom);
            b2 = 8'($urandom);
            if (r < 45)
            begin
                op = OP_ASSIGN;
                b1 = random_letter();
                b2 = random_letter();
                if ($urandom_range(0, 7) == 0)
                    b2 = (b1 ^ 8'h20);   // same letter, other case: clears the entry
            end
            else if (r < 80)
            begin
                op = OP_TRANSLATE;
                if ($urandom_range(0, 6) != 0)
                    b1 = 8'h61 + 8'($urandom_range(0, LETTERS - 1));
            end
            else if (r < 83)
                op = OP_CLEAR_ALL;
            else if (r < 86)
                op = OP_UNUSED;
            else
            begin
                op = OP_ASSIGN;
                if ($urandom_range(0, 1) == 0)
                    b1 = random_letter();
            end
            send_item(op, b1, b2, 1'b0, 8'h00, ST_TRANSLATED);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        drain = DRAIN_CYCLES;
        repeat (drain) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
